/* hdl/ggm_pkg.sv */
// Shared types and constants of the greedy graph mapper.
// No dependencies; every other file imports this package.
package ggm_pkg;
	localparam int MaxTasks = 64;
	localparam int MaxProcs = 64;
	localparam int ValueBits = 16;
	localparam int IdxBits = 6;
	localparam int CntBits = 7;
	localparam int AddrBits = 12;
	localparam int GainBits = 22;
	localparam int CostBits = 38;

	typedef enum logic [1:0] {
		OP_LOAD_WEIGHT = 2'd0,
		OP_LOAD_TIME   = 2'd1,
		OP_START       = 2'd2,
		OP_NONE        = 2'd3
	} opcode_t;

	localparam logic [CntBits-1:0] REG_TASK_COUNT = 7'd0;
	localparam logic [CntBits-1:0] REG_PROC_COUNT = 7'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FT_SUM,
		ST_FP_SUM,
		ST_EMIT,
		ST_GAIN,
		ST_COST,
		ST_ERR
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                clear;      // clear per-run arrays at index i
		logic                ft_acc;     // accumulate weight row sum
		logic                fp_acc;     // accumulate time row sum
		logic                row_end;    // compare the finished row sum
		logic                first;      // first row of a scan
		logic                gain_acc;   // gain update and max scan
		logic                cost_acc;   // cost accumulate over neighbours
		logic                cost_end;   // compare finished processor cost
		logic                commit;     // record assignment
		logic                scan_start; // reset scan bests
		logic [IdxBits-1:0]  i;
		logic [IdxBits-1:0]  j;
	} cmd_t;

	typedef struct packed {
		logic                row_skip;   // processor j is taken
		logic [IdxBits-1:0]  best_task;
		logic [IdxBits-1:0]  best_proc;
	} sts_t;

	function automatic logic [CntBits-1:0] clamp_count(input logic [CntBits-1:0] v);
		if (v == '0) return CntBits'(1);
		if (v > CntBits'(MaxTasks)) return CntBits'(MaxTasks);
		return v;
	endfunction
endpackage

/* hdl/ggm_stream_if.sv */
// Valid/ready channel interfaces for the mapper's items and results.
// Depends on ggm_pkg.
interface ggm_in_if import ggm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	logic [IdxBits-1:0]   row_index;
	logic [IdxBits-1:0]   column_index;
	logic [ValueBits-1:0] entry_value;
	modport source (output valid, opcode, row_index, column_index, entry_value, input ready);
	modport sink (input valid, opcode, row_index, column_index, entry_value, output ready);
endinterface

interface ggm_out_if import ggm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IdxBits-1:0] task_node;
	logic [IdxBits-1:0] processor_node;
	logic               error_flag;
	logic               last;
	modport source (output valid, task_node, processor_node, error_flag, last, input ready);
	modport sink (input valid, task_node, processor_node, error_flag, last, output ready);
endinterface

/* hdl/greedy_graph_mapper.sv */
// Greedy task-to-processor mapper. Load items (one per cycle while not busy) write 64x64
// weight and time matrices. A start item clears the run arrays, sums the weight and time
// rows to pick the first pair, then per further task scans gains and costs (through one
// multiplier), giving one result per task with last on the final one. Fewer processors
// than tasks gives a single error result. Depends on ggm_pkg, the stream interfaces,
// ggm_ctrl and ggm_datapath.
module greedy_graph_mapper import ggm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CntBits-1:0] cfg_index,
	input  logic [CntBits-1:0] cfg_data,
	ggm_in_if.sink             in_ch,
	ggm_out_if.source          out_ch
);
	logic [CntBits-1:0] task_count_q, proc_count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= CntBits'(MaxTasks);
			proc_count_q <= CntBits'(MaxProcs);
		end else if (cfg_we) begin
			if (cfg_index == REG_TASK_COUNT) task_count_q <= cfg_data;
			if (cfg_index == REG_PROC_COUNT) proc_count_q <= cfg_data;
		end
	end

	logic busy, acc;
	cmd_t cmd;
	sts_t sts;
	assign in_ch.ready = !busy;
	assign acc = in_ch.valid && in_ch.ready;

	ggm_ctrl u_ctrl (
		.clk, .arst_n,
		.start(acc && in_ch.opcode == OP_START),
		.nt_in(task_count_q), .np_in(proc_count_q),
		.sts, .out_ready(out_ch.ready), .busy, .cmd,
		.out_valid(out_ch.valid), .out_err(out_ch.error_flag), .out_last(out_ch.last)
	);

	ggm_datapath u_dp (
		.clk, .arst_n,
		.wr_w(acc && in_ch.opcode == OP_LOAD_WEIGHT),
		.wr_t(acc && in_ch.opcode == OP_LOAD_TIME),
		.wr_addr({in_ch.row_index, in_ch.column_index}),
		.wr_data(in_ch.entry_value),
		.cmd, .sts
	);

	assign out_ch.task_node = out_ch.error_flag ? '0 : sts.best_task;
	assign out_ch.processor_node = out_ch.error_flag ? '0 : sts.best_proc;
endmodule

/* hdl/ggm_datapath.sv */
// Datapath: both matrices, per-run arrays, the accumulators and argmax/argmin scans.
// Depends on ggm_pkg; driven by ggm_ctrl through cmd_t.
module ggm_datapath import ggm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_w,
	input  logic                 wr_t,
	input  logic [AddrBits-1:0]  wr_addr,
	input  logic [ValueBits-1:0] wr_data,
	input  cmd_t                 cmd,
	output sts_t                 sts
);
	logic [ValueBits-1:0] wmem [MaxTasks*MaxTasks];
	logic [ValueBits-1:0] tmem [MaxProcs*MaxProcs];
	logic [GainBits-1:0]  gain_q [MaxTasks];
	logic [MaxTasks-1:0]  done_q;
	logic [MaxProcs-1:0]  taken_q;
	logic [IdxBits-1:0]   map_q [MaxTasks];
	logic [IdxBits-1:0]   cur_t_q;
	logic [IdxBits-1:0]   bt_q, bp_q;

	// Stage 1: registered memory reads with aligned command.
	logic [ValueBits-1:0] w_s1, t_s1;
	logic [GainBits-1:0]  gain_s1;
	logic [IdxBits-1:0]   pw_s1;
	cmd_t                 cmd_s1;
	logic [AddrBits-1:0]  w_ra, t_ra;
	logic [GainBits-1:0]  g_new;

	// On the cost path the time matrix is read in the cycle after the weight, once the
	// neighbour's processor has come out of the assignment table.
	always_comb begin
		w_ra = {cur_t_q, cmd.i};
		t_ra = {cmd.j, cmd.i};
		if (cmd.ft_acc) w_ra = {cmd.j, cmd.i};
		if (cmd.cost_acc) w_ra = {bt_q, cmd.i};
		if (cmd_s1.cost_acc) t_ra = {cmd_s1.j, pw_s1};
	end

	always_ff @(posedge clk) begin
		if (wr_w) wmem[wr_addr] <= wr_data;
		if (wr_t) tmem[wr_addr] <= wr_data;
		w_s1 <= wmem[w_ra];
		t_s1 <= tmem[t_ra];
		gain_s1 <= gain_q[cmd.i];
		pw_s1 <= map_q[cmd.i];
	end

	assign g_new = gain_s1 + GainBits'(w_s1);

	always_ff @(posedge clk) begin
		if (cmd.clear) gain_q[cmd.i] <= '0;
		if (cmd_s1.gain_acc && !done_q[cmd_s1.i]) gain_q[cmd_s1.i] <= g_new;
		if (cmd.commit) map_q[bt_q] <= bp_q;
	end

	// Stage 2: weight delayed to meet the late time read.
	cmd_t                 cmd_s2;
	logic [ValueBits-1:0] w_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
		end else begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s2 <= w_s1;
	end

	// Stage 3: product register for the cost path.
	logic [2*ValueBits-1:0] prod_s3;
	logic                   pv_s3;
	logic                   end_s3;
	logic [IdxBits-1:0]     j_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s3 <= 1'b0;
			end_s3 <= 1'b0;
		end else begin
			pv_s3 <= cmd_s2.cost_acc && done_q[cmd_s2.i] && (w_s2 != '0);
			end_s3 <= cmd_s2.cost_end;
		end
	end
	always_ff @(posedge clk) begin
		prod_s3 <= w_s2 * t_s1;
		j_s3 <= cmd_s2.j;
	end

	logic [CostBits-1:0] acc_q, best_val_q;
	logic                found_q;
	logic [CostBits-1:0] g_ext;
	logic [CostBits:0]   csum;

	assign g_ext = CostBits'(g_new);
	assign csum = {1'b0, acc_q} + {{(CostBits+1-2*ValueBits){1'b0}}, prod_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			taken_q <= '0;
			cur_t_q <= '0;
			acc_q <= '0;
			best_val_q <= '0;
			bt_q <= '0;
			bp_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				done_q[cmd.i] <= 1'b0;
				taken_q[cmd.i] <= 1'b0;
			end
			if (cmd.scan_start) begin
				found_q <= 1'b0;
				acc_q <= '0;
			end
			if (cmd_s1.ft_acc || cmd_s1.fp_acc) begin
				acc_q <= acc_q + CostBits'(cmd_s1.ft_acc ? w_s1 : t_s1);
			end
			if (cmd_s1.row_end) begin
				logic [CostBits-1:0] s;
				s = acc_q + CostBits'(cmd_s1.ft_acc ? w_s1 : t_s1);
				acc_q <= '0;
				if (cmd_s1.first || (cmd_s1.ft_acc ? (s > best_val_q) : (s < best_val_q))) begin
					best_val_q <= s;
					if (cmd_s1.ft_acc) bt_q <= cmd_s1.j;
					else bp_q <= cmd_s1.j;
				end
			end
			// The best gain so far is kept in best_val_q while the gains are scanned.
			if (cmd_s1.gain_acc && !done_q[cmd_s1.i]) begin
				if (!found_q || g_ext > best_val_q) begin
					best_val_q <= g_ext;
					bt_q <= cmd_s1.i;
					found_q <= 1'b1;
				end
			end
			if (pv_s3) acc_q <= csum[CostBits] ? '1 : csum[CostBits-1:0];
			if (end_s3) begin
				logic [CostBits-1:0] c;
				c = pv_s3 ? (csum[CostBits] ? '1 : csum[CostBits-1:0]) : acc_q;
				acc_q <= '0;
				if (!found_q || c < best_val_q) begin
					best_val_q <= c;
					bp_q <= j_s3;
					found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				cur_t_q <= bt_q;
				done_q[bt_q] <= 1'b1;
				taken_q[bp_q] <= 1'b1;
			end
		end
	end

	assign sts.row_skip = taken_q[cmd.j];
	assign sts.best_task = bt_q;
	assign sts.best_proc = bp_q;
endmodule

/* hdl/ggm_ctrl.sv */
// Controller state machine sequencing scans over tasks and processors.
// Depends on ggm_pkg; commands ggm_datapath.
module ggm_ctrl import ggm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CntBits-1:0] nt_in,
	input  logic [CntBits-1:0] np_in,
	input  sts_t               sts,
	input  logic               out_ready,
	output logic               busy,
	output cmd_t               cmd,
	output logic               out_valid,
	output logic               out_err,
	output logic               out_last
);
	state_t state_q, state_d;
	logic [CntBits-1:0] nt_q, np_q, nt_d, np_d;
	logic [IdxBits-1:0] i_q, j_q, i_d, j_d;
	logic [CntBits-1:0] n_q, n_d;
	logic [2:0]         wait_q, wait_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nt_q <= '0; np_q <= '0; i_q <= '0; j_q <= '0; n_q <= '0; wait_q <= '0;
		end else begin
			state_q <= state_d;
			nt_q <= nt_d; np_q <= np_d; i_q <= i_d; j_q <= j_d; n_q <= n_d; wait_q <= wait_d;
		end
	end

	logic i_end, j_end_t, j_end_p;
	assign i_end = ({1'b0, i_q} == nt_q - 1'b1);

	always_comb begin
		state_d = state_q;
		nt_d = nt_q; np_d = np_q; i_d = i_q; j_d = j_q; n_d = n_q; wait_d = wait_q;
		cmd = '0;
		cmd.i = i_q;
		cmd.j = j_q;
		out_valid = 1'b0;
		out_err = 1'b0;
		out_last = 1'b0;
		busy = (state_q != ST_IDLE);
		j_end_t = ({1'b0, j_q} == nt_q - 1'b1);
		j_end_p = ({1'b0, j_q} == np_q - 1'b1);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					nt_d = clamp_count(nt_in);
					np_d = clamp_count(np_in);
					i_d = '0;
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				i_d = i_q + 1'b1;
				if (i_q == IdxBits'(MaxTasks - 1)) begin
					i_d = '0; j_d = '0;
					cmd.scan_start = 1'b1;
					state_d = (np_q < nt_q) ? ST_ERR : ST_FT_SUM;
				end
			end
			ST_ERR: begin
				out_valid = 1'b1; out_err = 1'b1; out_last = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			ST_FT_SUM: begin
				// Row j of the weight matrix, column i.
				cmd.ft_acc = 1'b1;
				cmd.first = (j_q == '0);
				i_d = i_q + 1'b1;
				if (i_end) begin
					cmd.row_end = 1'b1;
					i_d = '0;
					j_d = j_q + 1'b1;
					if (j_end_t) begin
						j_d = '0;
						state_d = ST_FP_SUM;
					end
				end
			end
			ST_FP_SUM: begin
				cmd.fp_acc = 1'b1;
				cmd.first = (j_q == '0);
				i_d = i_q + 1'b1;
				if ({1'b0, i_q} == np_q - 1'b1) begin
					cmd.row_end = 1'b1;
					i_d = '0;
					j_d = j_q + 1'b1;
					if (j_end_p) begin
						j_d = '0;
						wait_d = 3'd3;
						n_d = '0;
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				// Let the scan pipeline drain before the result is shown.
				if (wait_q != '0) begin
					wait_d = wait_q - 1'b1;
				end else begin
					out_valid = 1'b1;
					out_last = (n_q + 1'b1 == nt_q);
					if (out_ready) begin
						cmd.commit = 1'b1;
						n_d = n_q + 1'b1;
						if (out_last) begin
							state_d = ST_IDLE;
						end else begin
							i_d = '0;
							cmd.scan_start = 1'b1;
							state_d = ST_GAIN;
						end
					end
				end
			end
			ST_GAIN: begin
				cmd.gain_acc = 1'b1;
				i_d = i_q + 1'b1;
				if (i_end) begin
					i_d = '0; j_d = '0;
					wait_d = 3'd2;
					state_d = ST_COST;
				end
			end
			ST_COST: begin
				if (wait_q != '0) begin
					wait_d = wait_q - 1'b1;
					cmd.scan_start = (wait_q == 3'd1);
				end else if (sts.row_skip) begin
					j_d = j_q + 1'b1;
					if (j_end_p) begin
						wait_d = 3'd3;
						state_d = ST_EMIT;
					end
				end else begin
					// Cost of processor j over assigned neighbours i of the best task.
					cmd.cost_acc = 1'b1;
					i_d = i_q + 1'b1;
					if (i_end) begin
						cmd.cost_end = 1'b1;
						i_d = '0;
						j_d = j_q + 1'b1;
						if (j_end_p) begin
							wait_d = 3'd3;
							state_d = ST_EMIT;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result withdrawn");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> out_valid && !out_err) else $error("commit without result");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !out_valid) else $error("result while idle");
endmodule
